[hdl/assert_macros.svh]
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hdl/lzwd_pkg.sv]
package lzwd_pkg;

   localparam int CODE_W   = 12;
   localparam int BYTE_W   = 8;
   localparam int BITS_W   = 4;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 13;
   // wide enough for any dictionary address up to the largest supported size
   localparam int NF_W     = 17;

   localparam int unsigned FIRST_FREE = 257;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
   localparam logic [BITS_W-1:0]  MAX_BITS    = 4'd15;

   // result status codes, also used as the command kind
   localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd3;

   // one classified request handed from front to back
   typedef struct packed {
      logic [STATUS_W-1:0] kind;
      logic [CODE_W-1:0]   code;
      logic                close_vld;  // complete tail of entry open_addr-1
      logic                open_vld;   // open entry open_addr
      logic [NF_W-1:0]     open_addr;
      logic [BITS_W-1:0]   out_bits;
   } cmd_type;

endpackage

[hdl/lzw_code_decoder.sv]
// LZW code decoder. Each request carries one dictionary code; the block
// answers with the bytes of that code's string, first byte first, the last
// one marked by rsp_tlast, each with the width of the next code to unpack.
// Code 0 gives one end-of-stream response and restarts the dictionary; a
// code not yet defined gives one bad-code response and changes nothing;
// strings longer than MAX_WORD are cut to their first MAX_WORD bytes, all
// flagged truncated. A front stage classifies codes and keeps the entry
// counter and code width, a two-deep queue decouples it from the back end,
// which walks the parent chain in the dictionary memories one read per
// byte and then plays the string out of a stack memory. In the back end a
// data code runs the chain walk and then one registered stack read per byte
// played out; end and bad codes skip both. csr_wdata sets the entry count at
// which the dictionary wraps (reset 4096) and must be written only while
// idle; the block does not enforce this. No clearing pass after reset.
module lzw_code_decoder #(
   parameter int DICT_SIZE  = 4096,
   parameter int MAX_WORD   = 64,
   parameter int START_BITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] code, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [11:8] next_code_bits, [15:12] zero
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   lzwd_pkg::cmd_type             f_cmd, q_cmd;
   logic                          f_valid, f_ready, q_valid, q_ready;
   logic [lzwd_pkg::BYTE_W-1:0]   r_byte;
   logic [lzwd_pkg::BITS_W-1:0]   r_bits;

   lzwd_front #(
      .DICT_SIZE  (DICT_SIZE),
      .START_BITS (START_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_code  (req_tdata[11:0]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   lzwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   lzwd_back #(
      .DICT_SIZE (DICT_SIZE),
      .MAX_WORD  (MAX_WORD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (r_byte),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser),
      .rsp_bits   (r_bits)
   );

   assign rsp_tdata = {4'd0, r_bits, r_byte};

endmodule

[hdl/lzwd_queue.sv]
module lzwd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lzwd_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output lzwd_pkg::cmd_type out_cmd
);

   lzwd_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

[hdl/lzwd_front.sv]
module lzwd_front #(
   parameter int DICT_SIZE  = 4096,
   parameter int START_BITS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lzwd_pkg::CODE_W-1:0]   req_code,
   input  logic                          csr_we,
   input  logic [lzwd_pkg::LIMIT_W-1:0]  csr_wdata,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output lzwd_pkg::cmd_type             cmd
);

   localparam int NW = $clog2(DICT_SIZE) + 1;

   logic [NW-1:0]                   next_free_ff, next_free_in;
   logic [lzwd_pkg::BITS_W-1:0]     code_bits_ff, code_bits_in;
   logic                            have_prev_ff, have_prev_in;
   logic [lzwd_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [NW-1:0]                   nf_inc;
   logic [lzwd_pkg::BITS_W-1:0]     bits_inc;
   logic                            pow2, wrap, is_end, is_bad, accept;

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;
   assign accept    = req_valid && cmd_ready;

   // dictionary bookkeeping for a normal code
   always_comb begin
      is_end   = (req_code == '0);
      is_bad   = (32'(req_code) >= 32'(next_free_ff)) || (32'(req_code) >= 32'(DICT_SIZE));
      nf_inc   = next_free_ff + 1'b1;
      pow2     = ((nf_inc & (nf_inc - 1'b1)) == '0);
      bits_inc = (pow2 && code_bits_ff < lzwd_pkg::MAX_BITS) ? code_bits_ff + 1'b1
                                                              : code_bits_ff;
      wrap     = (32'(nf_inc) >= 32'(limit_ff)) || (32'(nf_inc) >= 32'(DICT_SIZE));
   end

   // classify and compute next state
   always_comb begin
      next_free_in  = next_free_ff;
      code_bits_in  = code_bits_ff;
      have_prev_in  = have_prev_ff;
      limit_in      = csr_we ? csr_wdata : limit_ff;
      cmd.code      = req_code;
      cmd.close_vld = 1'b0;
      cmd.open_vld  = 1'b0;
      cmd.open_addr = lzwd_pkg::NF_W'(next_free_ff);
      cmd.kind      = lzwd_pkg::ST_DATA;
      cmd.out_bits  = code_bits_ff;
      if (is_end) begin
         cmd.kind     = lzwd_pkg::ST_END;
         cmd.out_bits = lzwd_pkg::BITS_W'(START_BITS);
         if (accept) begin
            next_free_in = NW'(lzwd_pkg::FIRST_FREE);
            code_bits_in = lzwd_pkg::BITS_W'(START_BITS);
            have_prev_in = 1'b0;
         end
      end else if (is_bad) begin
         cmd.kind = lzwd_pkg::ST_BAD;
      end else begin
         cmd.close_vld = have_prev_ff;
         cmd.open_vld  = (32'(next_free_ff) < 32'(DICT_SIZE));
         if (wrap) begin
            cmd.out_bits = lzwd_pkg::BITS_W'(START_BITS);
         end else begin
            cmd.out_bits = bits_inc;
         end
         if (accept) begin
            if (wrap) begin
               next_free_in = NW'(lzwd_pkg::FIRST_FREE);
               code_bits_in = lzwd_pkg::BITS_W'(START_BITS);
               have_prev_in = 1'b0;
            end else begin
               next_free_in = nf_inc;
               code_bits_in = bits_inc;
               have_prev_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= NW'(lzwd_pkg::FIRST_FREE);
         code_bits_ff <= lzwd_pkg::BITS_W'(START_BITS);
         have_prev_ff <= 1'b0;
         limit_ff     <= lzwd_pkg::LIMIT_RESET;
      end else begin
         next_free_ff <= next_free_in;
         code_bits_ff <= code_bits_in;
         have_prev_ff <= have_prev_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

[hdl/lzwd_back.sv]
module lzwd_back #(
   parameter int DICT_SIZE = 4096,
   parameter int MAX_WORD  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  lzwd_pkg::cmd_type             cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lzwd_pkg::BYTE_W-1:0]   rsp_byte,
   output logic                          rsp_last,
   output logic [lzwd_pkg::STATUS_W-1:0] rsp_status,
   output logic [lzwd_pkg::BITS_W-1:0]   rsp_bits
);

   localparam int AW = $clog2(DICT_SIZE);
   localparam int LW = $clog2(DICT_SIZE) + 1;
   localparam int SW = $clog2(MAX_WORD);
   localparam int CW = $clog2(MAX_WORD + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOK    = 3'd1;
   localparam logic [2:0] S_FETCH   = 3'd2;
   localparam logic [2:0] S_STEP    = 3'd3;
   localparam logic [2:0] S_EMIT_RD = 3'd4;
   localparam logic [2:0] S_EMIT_WR = 3'd5;
   localparam logic [2:0] S_ONE     = 3'd6;

   // dictionary and string stack
   logic [lzwd_pkg::CODE_W-1:0] parent_mem [DICT_SIZE];
   logic [lzwd_pkg::BYTE_W-1:0] tail_mem   [DICT_SIZE];
   logic [lzwd_pkg::BYTE_W-1:0] head_mem   [DICT_SIZE];
   logic [LW-1:0]               len_mem    [DICT_SIZE];
   logic [lzwd_pkg::BYTE_W-1:0] stack_mem  [MAX_WORD];

   logic [lzwd_pkg::CODE_W-1:0] parent_rd_ff;
   logic [lzwd_pkg::BYTE_W-1:0] tail_rd_ff, head_rd_ff, stack_rd_ff;
   logic [LW-1:0]               len_rd_ff;

   logic [2:0]                  state_ff, state_in;
   lzwd_pkg::cmd_type           cmd_ff, cmd_in;
   logic [lzwd_pkg::CODE_W-1:0] cur_ff, cur_in;
   logic [LW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic                        trunc_ff, trunc_in;

   logic                        out_valid_ff, out_valid_in;
   logic [lzwd_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                        out_last_ff, out_last_in;
   logic [lzwd_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [lzwd_pkg::BITS_W-1:0] out_bits_ff, out_bits_in;

   logic                        out_free, load;
   logic                        code_lit, cur_lit;
   logic [lzwd_pkg::BYTE_W-1:0] code_head, step_byte;
   logic [LW-1:0]               code_len;
   logic                        wr_dict, wr_close, wr_stack;

   assign out_free = !out_valid_ff || rsp_ready;

   // literal decode for the request code and for the walk position
   always_comb begin
      code_lit  = (cmd_ff.code >= 12'd1) && (cmd_ff.code <= 12'd256);
      cur_lit   = (cur_ff >= 12'd1) && (cur_ff <= 12'd256);
      code_head = code_lit ? lzwd_pkg::BYTE_W'(cmd_ff.code - 1'b1) : head_rd_ff;
      code_len  = code_lit ? LW'(1) : len_rd_ff;
      step_byte = cur_lit ? lzwd_pkg::BYTE_W'(cur_ff - 1'b1) : tail_rd_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      trunc_in      = trunc_ff;
      cmd_ready     = 1'b0;
      load          = 1'b0;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_bits_in   = out_bits_ff;
      wr_dict       = 1'b0;
      wr_close      = 1'b0;
      wr_stack      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = (cmd.kind == lzwd_pkg::ST_DATA) ? S_LOOK : S_ONE;
            end
         end
         S_LOOK: begin
            wr_close = cmd_ff.close_vld;
            wr_dict  = cmd_ff.open_vld;
            cur_in   = cmd_ff.code;
            pos_in   = code_len - 1'b1;
            trunc_in = (32'(code_len) > 32'(MAX_WORD));
            cnt_in   = trunc_in ? CW'(MAX_WORD) : CW'(code_len);
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            wr_stack = (32'(pos_ff) < 32'(MAX_WORD));
            if (cur_lit || pos_ff == '0) begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               cur_in = parent_rd_ff;
               pos_in = pos_ff - 1'b1;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               load          = 1'b1;
               out_byte_in   = stack_rd_ff;
               out_last_in   = (idx_ff + 1'b1 == cnt_ff);
               out_status_in = trunc_ff ? lzwd_pkg::ST_TRUNC : lzwd_pkg::ST_DATA;
               out_bits_in   = cmd_ff.out_bits;
               idx_in        = idx_ff + 1'b1;
               state_in      = out_last_in ? S_IDLE : S_EMIT_RD;
            end
         end
         S_ONE: begin
            if (out_free) begin
               load          = 1'b1;
               out_byte_in   = '0;
               out_last_in   = 1'b1;
               out_status_in = cmd_ff.kind;
               out_bits_in   = cmd_ff.out_bits;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      trunc_ff <= trunc_in;
      if (load) begin
         out_byte_ff   <= out_byte_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
         out_bits_ff   <= out_bits_in;
      end
   end

   // head and length lookup at the queue head's code
   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[AW'(cmd.code)];
      len_rd_ff  <= len_mem[AW'(cmd.code)];
      if (wr_dict) begin
         head_mem[AW'(cmd_ff.open_addr)] <= code_head;
         len_mem[AW'(cmd_ff.open_addr)]  <= code_len + 1'b1;
      end
   end

   // chain walk reads follow the next walk position
   always_ff @(posedge clock) begin
      parent_rd_ff <= parent_mem[AW'(cur_in)];
      if (wr_dict) begin
         parent_mem[AW'(cmd_ff.open_addr)] <= cmd_ff.code;
      end
   end

   always_ff @(posedge clock) begin
      tail_rd_ff <= tail_mem[AW'(cur_in)];
      if (wr_close) begin
         tail_mem[AW'(cmd_ff.open_addr - 1'b1)] <= code_head;
      end
   end

   // string stack, filled last byte first
   always_ff @(posedge clock) begin
      stack_rd_ff <= stack_mem[idx_ff[SW-1:0]];
      if (wr_stack) begin
         stack_mem[pos_ff[SW-1:0]] <= step_byte;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_status = out_status_ff;
   assign rsp_bits   = out_bits_ff;

endmodule

[hdl/lzwd_checker.sv]
`include "assert_macros.svh"

module lzwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // end of stream is a lone zero byte and reports the start width
   `ASSERT_IMPLIES(a_end_form, clock, reset, rsp_tvalid && rsp_tuser == lzwd_pkg::ST_END, rsp_tlast && rsp_tdata[7:0] == 8'd0 && rsp_tdata[11:8] == 4'd9)

   // bad code is a lone zero byte
   `ASSERT_IMPLIES(a_bad_form, clock, reset, rsp_tvalid && rsp_tuser == lzwd_pkg::ST_BAD, rsp_tlast && rsp_tdata[7:0] == 8'd0)

   // reported width stays in the legal range, padding stays zero
   `ASSERT_IMPLIES(a_bits_range, clock, reset, rsp_tvalid, rsp_tdata[11:8] >= 4'd9 && rsp_tdata[15:12] == 4'd0)

endmodule

bind lzw_code_decoder lzwd_checker u_lzwd_checker (.*);

[bench/lzw_decode_checker.sv]
`timescale 1ns / 100ps

// Watches the code and byte channels, predicts the decoded bytes and
// compares every response against the oldest prediction.
module lzw_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,
   output int          fails,
   output int          pending
);

   localparam int DICT = 4096;
   localparam int WORD = 64;

   typedef struct packed {
      logic [lzwd_pkg::BYTE_W-1:0]   data_byte;
      logic                          last;
      logic [lzwd_pkg::STATUS_W-1:0] status;
      logic [lzwd_pkg::BITS_W-1:0]   bits;
   } byte_rsp_type;

   byte_rsp_type decoded_q[$];

   logic [lzwd_pkg::CODE_W-1:0] parent_mem [DICT];
   logic [lzwd_pkg::BYTE_W-1:0] tail_mem   [DICT];
   logic [lzwd_pkg::BYTE_W-1:0] head_mem   [DICT];
   int unsigned       next_entry;
   int unsigned       width_bits;
   bit                have_prev;
   int unsigned       wrap_limit;

   assign pending = decoded_q.size();

   function automatic logic [lzwd_pkg::BYTE_W-1:0] first_byte(int unsigned c);
      if (c >= 1 && c <= 256) return lzwd_pkg::BYTE_W'(c - 1);
      return head_mem[c];
   endfunction

   function automatic void restart();
      next_entry = lzwd_pkg::FIRST_FREE;
      width_bits = 9;
      have_prev  = 0;
   endfunction

   function automatic void push_rsp(logic [7:0] b, bit l, logic [1:0] st);
      byte_rsp_type r;
      r.data_byte = b;
      r.last      = l;
      r.status    = st;
      r.bits      = lzwd_pkg::BITS_W'(width_bits);
      decoded_q.push_back(r);
   endfunction

   // Decode one code: complete the pending entry, walk the chain, open a new entry
   function automatic void decode_code(int unsigned c);
      logic [7:0] chain[$];
      int unsigned p, e, lim, cnt;
      logic [1:0] st;
      if (c == 0) begin
         restart();
         push_rsp(8'd0, 1'b1, lzwd_pkg::ST_END);
         return;
      end
      if (c >= next_entry) begin
         push_rsp(8'd0, 1'b1, lzwd_pkg::ST_BAD);
         return;
      end
      // tail of the previous entry; KwKwK takes that entry's own head
      if (have_prev && next_entry > lzwd_pkg::FIRST_FREE) begin
         e = next_entry - 1;
         tail_mem[e] = (c == e) ? head_mem[e] : first_byte(c);
      end
      p = c;
      while (p >= lzwd_pkg::FIRST_FREE) begin
         chain.push_front(tail_mem[p]);
         p = parent_mem[p];
      end
      chain.push_front(lzwd_pkg::BYTE_W'(p - 1));
      if (next_entry < DICT) begin
         parent_mem[next_entry] = lzwd_pkg::CODE_W'(c);
         head_mem[next_entry]   = first_byte(c);
         tail_mem[next_entry]   = 8'd0;
      end
      next_entry++;
      have_prev = 1;
      if ((next_entry & (next_entry - 1)) == 0 && width_bits < 15) width_bits++;
      lim = wrap_limit < 258 ? 258 : (wrap_limit > DICT ? DICT : wrap_limit);
      if (next_entry >= lim) restart();
      cnt = chain.size() < WORD ? chain.size() : WORD;
      st  = chain.size() > WORD ? lzwd_pkg::ST_TRUNC : lzwd_pkg::ST_DATA;
      for (int k = 0; k < cnt; k++) push_rsp(chain[k], k + 1 == cnt, st);
   endfunction

   always @(posedge clock) begin
      byte_rsp_type want, got;
      if (reset) begin
         restart();
         wrap_limit = 4096;
         decoded_q.delete();
         fails = 0;
      end else begin
         if (csr_we) wrap_limit = csr_wdata;
         if (req_tvalid && req_tready) decode_code(req_tdata[11:0]);
         // compare responses in order
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tlast, rsp_tuser, rsp_tdata[11:8]};
            if (decoded_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected response, expected none, actual byte %h last %b status %0d bits %0d",
                        $time, got.data_byte, got.last, got.status, got.bits);
            end else begin
               want = decoded_q.pop_front();
               if (want !== got || rsp_tdata[15:12] !== 4'd0) begin
                  fails++;
                  $display("%0t: expected byte %h last %b status %0d bits %0d, actual byte %h last %b status %0d bits %0d",
                           $time, want.data_byte, want.last, want.status, want.bits,
                           got.data_byte, got.last, got.status, got.bits);
               end
            end
         end
      end
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [12:0] csr_wdata = 0;
   int          fails;
   int          pending;

   int unsigned tx_idle = 0;
   int unsigned rx_idle = 0;
   // mirror of the entry counter so that stimulus stays well formed
   int unsigned free_entry = lzwd_pkg::FIRST_FREE;
   int unsigned wrap_at = 4096;
   int          n_codes = 0;
   int          n_trunc = 0;

   always #1 clock = ~clock;

   lzw_code_decoder dut (.*);

   lzw_decode_checker checker_i (.*);

   // receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle);

   task automatic send_code(int unsigned c);
      int unsigned lim;
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'd0, 12'(c)};
      do @(posedge clock); while (!req_tready);
      n_codes++;
      lim = wrap_at < 258 ? 258 : (wrap_at > 4096 ? 4096 : wrap_at);
      if (c == 0) free_entry = lzwd_pkg::FIRST_FREE;
      else if (c < free_entry) begin
         free_entry++;
         if (free_entry >= lim) free_entry = lzwd_pkg::FIRST_FREE;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_limit(int unsigned v);
      drain();
      csr_we    <= 1;
      csr_wdata <= 13'(v);
      @(posedge clock);
      csr_we <= 0;
      wrap_at = v;
   endtask

   // mostly valid codes, many growing the newest entry, some bad and end codes
   task automatic random_codes(int n);
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 4) send_code(0);
         else if (r < 12 && free_entry <= 4095) send_code($urandom_range(4095, free_entry));
         else if (r < 45 && free_entry > lzwd_pkg::FIRST_FREE) send_code(free_entry - 1);
         else if (r < 75) send_code($urandom_range(free_entry - 1, 1));
         else send_code($urandom_range(256, 1));
      end
   endtask

   // KwKwK chain past the word limit
   task automatic long_string();
      send_code($urandom_range(256, 1));
      for (int i = 0; i < 66; i++) send_code(free_entry - 1);
      n_trunc++;
   endtask

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: literal extremes, KwKwK, bad codes, end of stream, tiny wrap
      tx_idle = 17;
      rx_idle = 80;
      set_limit(258);
      send_code(1);
      send_code(256);
      send_code(1);
      send_code(257);
      send_code(4095);
      send_code(2048);
      send_code(0);
      set_limit(300);
      send_code(129);
      send_code(257);
      send_code(258);
      send_code(259);
      send_code(128);
      send_code(260);
      send_code(free_entry);
      send_code(0);
      random_codes(6);

      // limit below the floor, long strings
      tx_idle = 80;
      rx_idle = 17;
      set_limit(0);
      random_codes(4);
      set_limit(4096);
      long_string();
      random_codes(4);

      // pause until everything is out
      drain();
      random_codes(4);

      // limit above the dictionary, then a mid-size limit
      tx_idle = 0;
      rx_idle = 0;
      set_limit(8191);
      send_code(0);
      random_codes(4);
      set_limit(1000);
      random_codes(4);

      drain();
      $display("Sent %0d codes over dictionary limits 258 to 8191, %0d strings past the word limit.",
               n_codes, n_trunc);
      if (fails == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
